>>> hw/rtl/bounded_deque_with_insert_delete_macros.svh
// assertion macros
`ifndef BOUNDED_DEQUE_WITH_INSERT_DELETE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_INSERT_DELETE_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/bdq_pkg.sv
package bdq_pkg;
    localparam int unsigned DefCapacity = 16;
    localparam int unsigned CntW = 5;

    typedef enum logic [2:0] {
        REQ_ADD_FRONT  = 3'd0,
        REQ_ADD_BACK   = 3'd1,
        REQ_TAKE_FRONT = 3'd2,
        REQ_TAKE_BACK  = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_DELETE     = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_FRONT,
        S_BACK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_req;
        logic scan_start;
        logic scan_step;
        logic up_step;
        logic down_step;
        logic write_new;
        logic cnt_inc;
        logic cnt_dec;
        logic rd_front;
        logic rd_back;
        logic cap_front;
        logic set_status;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       empty;
        logic       full;
        logic       idx_bad;
        logic       match;
        logic       scan_end;
        logic       up_end;
        logic       down_end;
    } sts_t;
endpackage

>>> hw/rtl/bdq_if.sv
interface bdq_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/bounded_deque_with_insert_delete.sv
// channel | direction | payload
// req     | sink      | req_type, value, index
// rsp     | source    | status, count, front_value, back_value
// a result passes the search, front, back and done states when nothing has to move
// push back and insert at the end move no entry; push front and insert shift up
// count-index entries; pop front and delete move or compare one entry per cycle
// the next item can be accepted in the cycle after the result is registered
// reset clears the element count; the store itself is not cleared
// a result waiting in the output register holds the controller until it leaves
module bounded_deque_with_insert_delete
    import bdq_pkg::*;
#(
    parameter int unsigned CAPACITY = DefCapacity
)
(
    input logic clk,
    input logic rst_n,
    bdq_if.sink req,
    bdq_if.source rsp
);
    cmd_t cmd;
    sts_t sts;
    logic in_ready;
    logic out_set;
    logic out_valid_reg;
    logic [2:0] status;
    logic [CntW-1:0] count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [2:0] st_q;
    logic [CntW-1:0] cnt_q;
    logic [31:0] fr_q;
    logic [31:0] bk_q;

    assign req.ready = in_ready;

    bdq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(req.valid & in_ready),
        .out_busy(out_valid_reg & ~rsp.ready), .sts(sts),
        .in_ready(in_ready), .out_set(out_set), .cmd(cmd)
    );

    bdq_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_req(req.data[2:0]), .in_value(req.data[34:3]), .in_index(req.data[42:35]),
        .sts(sts), .status(status), .count(count),
        .front_value(front_value), .back_value(back_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_set)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_set)
        begin
            st_q <= status;
            cnt_q <= count;
            fr_q <= front_value;
            bk_q <= back_value;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data = {bk_q, fr_q, cnt_q, st_q};
endmodule

>>> hw/rtl/bdq_ctrl.sv
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic out_busy,
    input  sts_t sts,
    output logic in_ready,
    output logic out_set,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.status = ST_OK;
        in_ready = 1'b0;
        out_set = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load_req = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = S_FRONT;
                cmd.set_status = 1'b1;
                unique case (sts.req) inside
                    REQ_ADD_FRONT, REQ_ADD_BACK, REQ_INSERT:
                    begin
                        if (sts.req == REQ_INSERT && sts.idx_bad)
                        begin
                            cmd.status = ST_RANGE;
                        end
                        else if (sts.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    REQ_TAKE_FRONT, REQ_TAKE_BACK:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status = ST_EMPTY;
                        end
                        else if (sts.req == REQ_TAKE_BACK)
                        begin
                            cmd.cnt_dec = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next = S_SHIFT_DOWN;
                        end
                    end
                    REQ_DELETE:
                    begin
                        cmd.set_status = 1'b0;
                        if (sts.scan_end)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = ST_NOTFOUND;
                        end
                        else if (sts.match)
                        begin
                            cmd.set_status = 1'b1;
                            state_next = S_SHIFT_DOWN;
                        end
                        else
                        begin
                            cmd.scan_step = 1'b1;
                            state_next = S_SEARCH;
                        end
                    end
                    default:
                    begin
                        cmd.status = ST_RANGE;
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                if (sts.up_end)
                begin
                    cmd.write_new = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next = S_FRONT;
                end
                else
                begin
                    cmd.up_step = 1'b1;
                end
            end
            S_SHIFT_DOWN:
            begin
                if (sts.down_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next = S_FRONT;
                end
                else
                begin
                    cmd.down_step = 1'b1;
                end
            end
            S_FRONT:
            begin
                cmd.rd_front = 1'b1;
                state_next = S_BACK;
            end
            S_BACK:
            begin
                cmd.cap_front = 1'b1;
                cmd.rd_back = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    out_set = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> hw/rtl/bdq_dp.sv
module bdq_dp
    import bdq_pkg::*;
#(
    parameter int unsigned CAPACITY = DefCapacity
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [2:0]         in_req,
    input  logic signed [31:0] in_value,
    input  logic [7:0]         in_index,
    output sts_t               sts,
    output logic [2:0]         status,
    output logic [CntW-1:0]    count,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value
);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned PW = $clog2(CAPACITY + 1);

    logic [31:0]   mem [CAPACITY];
    logic [PW-1:0] cnt_reg;
    logic [2:0]    req_reg;
    logic [31:0]   val_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] ptr_reg;
    logic [31:0]   rd_reg;
    logic [2:0]    status_reg;
    logic [31:0]   front_reg;
    logic          idx_bad_reg;
    logic [PW-1:0] tgt;
    logic          ins;

    assign ins = (req_reg != 3'(REQ_TAKE_FRONT)) && (req_reg != 3'(REQ_DELETE));

    always_comb
    begin
        case (req_reg)
            REQ_ADD_BACK: tgt = cnt_reg;
            REQ_INSERT:   tgt = pos_reg;
            default:      tgt = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= in_req;
            val_reg <= in_value;
            pos_reg <= PW'(in_index);
            idx_bad_reg <= ({24'd0, in_index} > 32'(cnt_reg));
            ptr_reg <= '0;
            rd_reg <= mem[0];
        end
        if (cmd.scan_start)
        begin
            ptr_reg <= ins ? cnt_reg : '0;
        end
        if (cmd.scan_step)
        begin
            ptr_reg <= ptr_reg + 1'b1;
            rd_reg <= mem[AW'(ptr_reg + 1'b1)];
        end
        if (cmd.up_step)
        begin
            mem[AW'(ptr_reg)] <= mem[AW'(ptr_reg - 1'b1)];
            ptr_reg <= ptr_reg - 1'b1;
        end
        if (cmd.down_step)
        begin
            mem[AW'(ptr_reg)] <= mem[AW'(ptr_reg + 1'b1)];
            ptr_reg <= ptr_reg + 1'b1;
        end
        if (cmd.write_new)
        begin
            mem[AW'(tgt)] <= val_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.rd_front)
        begin
            rd_reg <= mem[0];
        end
        if (cmd.rd_back)
        begin
            rd_reg <= mem[AW'(cnt_reg - 1'b1)];
        end
        if (cmd.cap_front)
        begin
            front_reg <= rd_reg;
        end
    end

    always_comb
    begin
        sts.req = req_reg;
        sts.empty = (cnt_reg == '0);
        sts.full = (32'(cnt_reg) >= CAPACITY);
        sts.idx_bad = idx_bad_reg;
        sts.match = (rd_reg == val_reg);
        sts.scan_end = (ptr_reg >= cnt_reg);
        sts.up_end = (ptr_reg == tgt);
        sts.down_end = (ptr_reg + 1'b1 >= cnt_reg);
    end

    assign status = status_reg;
    assign count = CntW'(cnt_reg);
    assign front_value = (cnt_reg == '0) ? 32'sd0 : $signed(front_reg);
    assign back_value = (cnt_reg == '0) ? 32'sd0 : $signed(rd_reg);
endmodule

>>> hw/rtl/bdq_checker.sv
`include "bounded_deque_with_insert_delete_macros.svh"
module bdq_checker
    import bdq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic [71:0] rsp_data
);
    `ASSERT_IMPL(a_cnt_range, clk, rst_n, rsp_valid, rsp_data[7:3] <= 5'd16)
    `ASSERT_IMPL(a_status_range, clk, rst_n, rsp_valid, rsp_data[2:0] <= 3'd4)
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule

bind bounded_deque_with_insert_delete bdq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

>>> sim/bdq_checker.sv
module bdq_scoreboard
    import bdq_pkg::*;
#(
    parameter int unsigned CAPACITY = DefCapacity
)
(
    input logic clk,
    input logic rst_n,
    bdq_if req_mon,
    bdq_if rsp_mon,
    output int errors,
    output int pending
);
    typedef struct packed {
        logic [31:0] back_value;
        logic [31:0] front_value;
        logic [4:0]  count;
        status_t     status;
    } deque_result_t;

    logic [31:0]   deque_store [CAPACITY];
    int unsigned   deque_count;
    deque_result_t expected_results [$];

    function automatic status_t place_entry(int unsigned pos, logic [31:0] v);
        if (deque_count >= CAPACITY)
            return ST_FULL;
        for (int unsigned i = deque_count; i > pos; i--)
            deque_store[i] = deque_store[i - 1];
        deque_store[pos] = v;
        deque_count++;
        return ST_OK;
    endfunction

    function automatic void remove_entry(int unsigned pos);
        for (int unsigned i = pos; i + 1 < deque_count; i++)
            deque_store[i] = deque_store[i + 1];
        deque_count--;
    endfunction

    function automatic deque_result_t apply_request(logic [2:0] kind, logic [31:0] v,
                                                    logic [7:0] idx);
        deque_result_t r;
        status_t st;
        int unsigned hit;
        st = ST_OK;
        hit = deque_count;
        case (kind)
            REQ_ADD_FRONT: st = place_entry(0, v);
            REQ_ADD_BACK:  st = place_entry(deque_count, v);
            REQ_TAKE_FRONT:
            begin
                if (deque_count == 0)
                    st = ST_EMPTY;
                else
                    remove_entry(0);
            end
            REQ_TAKE_BACK:
            begin
                if (deque_count == 0)
                    st = ST_EMPTY;
                else
                    deque_count--;
            end
            REQ_INSERT:
            begin
                if (idx > deque_count)
                    st = ST_RANGE;
                else
                    st = place_entry(idx, v);
            end
            REQ_DELETE:
            begin
                for (int unsigned i = 0; i < deque_count; i++)
                begin
                    if (deque_store[i] == v && hit == deque_count)
                        hit = i;
                end
                if (hit == deque_count)
                    st = ST_NOTFOUND;
                else
                    remove_entry(hit);
            end
            default: st = ST_RANGE;
        endcase
        r.status = st;
        r.count = deque_count[4:0];
        r.front_value = (deque_count == 0) ? 32'd0 : deque_store[0];
        r.back_value = (deque_count == 0) ? 32'd0 : deque_store[deque_count - 1];
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        deque_result_t got;
        if (!rst_n)
        begin
            deque_count = 0;
            errors = 0;
            expected_results.delete();
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
                expected_results = {expected_results,
                                    apply_request(req_mon.data[2:0],
                                                  req_mon.data[34:3],
                                                  req_mon.data[42:35])};
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got = rsp_mon.data;
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation waiting: %h", got);
                    errors++;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, got.count);
                        errors++;
                    end
                    if (got.front_value !== want.front_value)
                    begin
                        $error("front_value: expected %0d, actual %0d",
                               $signed(want.front_value), $signed(got.front_value));
                        errors++;
                    end
                    if (got.back_value !== want.back_value)
                    begin
                        $error("back_value: expected %0d, actual %0d",
                               $signed(want.back_value), $signed(got.back_value));
                        errors++;
                    end
                end
            end
        end
    end
endmodule

>>> sim/tb.sv
module tb
    import bdq_pkg::*;
();
    localparam int unsigned CycleLimit = 400000;
    localparam logic [2:0] ReqBadLo = 3'd6;
    localparam logic [2:0] ReqBadHi = 3'd7;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   eager;
    logic [31:0] value_pool [8];

    bdq_if #(.W(43)) req_ch ();
    bdq_if #(.W(72)) rsp_ch ();

    bounded_deque_with_insert_delete u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    bdq_scoreboard u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_mon (req_ch),
        .rsp_mon (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_req(logic [2:0] kind, logic [31:0] v, logic [7:0] idx);
        int gap;
        gap = eager ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= {idx, v, kind};
        forever
        begin
            @(negedge clk);
            if (req_ch.ready)
                break;
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 2) != 0)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // response side: long hold-off first so the block backs up
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        repeat (400) @(posedge clk);
        forever
        begin
            gap = eager ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            forever
            begin
                @(negedge clk);
                if (rsp_ch.valid)
                    break;
                @(posedge clk);
            end
            @(posedge clk);
        end
    end

    initial
    begin
        int r;
        int pick;
        int fill_bias;
        logic [2:0] kind;
        eager = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'hffff_ffff;
        value_pool[3] = 32'd0;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, bad codes, ends, fill, full, range
        send_req(REQ_TAKE_FRONT, 32'd0, 8'd0);
        send_req(REQ_TAKE_BACK, 32'd0, 8'd0);
        send_req(REQ_DELETE, 32'd0, 8'd0);
        send_req(ReqBadLo, 32'hffff_ffff, 8'hff);
        send_req(ReqBadHi, 32'd0, 8'd0);
        send_req(REQ_INSERT, 32'd5, 8'd1);
        send_req(REQ_ADD_FRONT, 32'h8000_0000, 8'd0);
        send_req(REQ_ADD_BACK, 32'h7fff_ffff, 8'd0);
        send_req(REQ_INSERT, 32'hffff_ffff, 8'd0);
        send_req(REQ_INSERT, 32'd1, 8'd3);
        send_req(REQ_INSERT, 32'd2, 8'd2);
        send_req(REQ_INSERT, 32'd3, 8'd255);
        for (int i = 0; i < 11; i++)
            send_req(REQ_ADD_BACK, 32'(i), 8'd0);
        send_req(REQ_ADD_FRONT, 32'd9, 8'd0);
        send_req(REQ_ADD_BACK, 32'd9, 8'd0);
        send_req(REQ_INSERT, 32'd9, 8'd16);
        send_req(REQ_INSERT, 32'd9, 8'd17);
        send_req(REQ_DELETE, 32'd5, 8'd0);
        send_req(REQ_DELETE, 32'd1234, 8'd0);
        send_req(REQ_TAKE_FRONT, 32'd0, 8'd0);
        send_req(REQ_TAKE_BACK, 32'd0, 8'd0);

        for (int n = 0; n < 1050; n++)
        begin
            if (n % 100 == 0)
            begin
                eager = ($urandom_range(0, 3) == 0);
                fill_bias = $urandom_range(20, 80);
            end
            r = $urandom_range(0, 99);
            pick = $urandom_range(0, 2);
            if (r < 2)
                kind = (pick == 0) ? ReqBadLo : ReqBadHi;
            else if ($urandom_range(0, 99) < fill_bias)
                kind = (pick == 0) ? REQ_ADD_FRONT :
                       ((pick == 1) ? REQ_ADD_BACK : REQ_INSERT);
            else
                kind = (pick == 0) ? REQ_TAKE_FRONT :
                       ((pick == 1) ? REQ_TAKE_BACK : REQ_DELETE);
            send_req(kind, pick_value(),
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17)));
        end
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
